// ===== rtl/ios_pkg.sv =====
`default_nettype none

package ios_pkg;

   localparam int unsigned SCORE_W = 7;
   localparam int unsigned SPEED_W = 10;
   localparam int unsigned TURN_W = 11;
   localparam int unsigned PROX_W = 12;
   localparam int unsigned STEP_W = 16;
   localparam int unsigned CLEAR_W = 7;
   localparam int unsigned LIMIT_W = 8;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 10;
   localparam int unsigned SENSOR_COUNT = 8;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CRUISE_SPEED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAUTION_SPEED = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_LEVEL = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STARTUP_STEP_LIMIT = 2'd3;

   localparam logic [SPEED_W-1:0] CRUISE_SPEED_RESET = 10'd1000;
   localparam logic [SPEED_W-1:0] CAUTION_SPEED_RESET = 10'd800;
   localparam logic [CLEAR_W-1:0] CLEAR_LEVEL_RESET = 7'd90;
   localparam logic [LIMIT_W-1:0] STARTUP_STEP_LIMIT_RESET = 8'd10;

   localparam logic [SPEED_W-1:0] SIDE_SPEED = 10'd350;
   localparam logic [SPEED_W-1:0] STARTUP_SPEED_BASE = 10'd100;
   localparam logic signed [TURN_W-1:0] TURN_LEFT_FULL = 11'sd1000;
   localparam logic signed [TURN_W-1:0] TURN_RIGHT_FULL = -11'sd1000;

   typedef logic [SCORE_W-1:0] score_type;

   typedef struct packed {
      logic [SPEED_W-1:0] cruise_speed;
      logic [SPEED_W-1:0] caution_speed;
      logic [CLEAR_W-1:0] clear_level;
      logic [LIMIT_W-1:0] startup_step_limit;
   } cfg_type;

   typedef struct packed {
      logic front_clear;
      logic front_turn_right;
      logic any_near;
      logic side_hit;
      logic [SCORE_W-1:0] side_turn;
      logic surrounded;
      logic steps_below;
      logic [LIMIT_W-1:0] steps;
   } item_type;

endpackage

`default_nettype wire

// ===== rtl/ios_front.sv =====
`default_nettype none

module ios_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ios_pkg::cfg_type              cfg,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [ios_pkg::PROX_W-1:0]    prox [ios_pkg::SENSOR_COUNT],
   input  wire logic signed [ios_pkg::STEP_W-1:0] steps_left,
   input  wire logic signed [ios_pkg::STEP_W-1:0] steps_right,
   output logic                               item_push,
   input  wire logic                          item_full,
   output ios_pkg::item_type                  item
);
   import ios_pkg::*;

   localparam logic [PROX_W-1:0] RAW_CLIP = 12'd3000;
   localparam logic [PROX_W-1:0] RECIP_30 = 12'd2185;
   localparam score_type SCORE_FULL = 7'd100;
   localparam score_type SCORE_GAP = 7'd80;

   logic      a_valid_ff, a_valid_in;
   score_type a_score_ff [SENSOR_COUNT];
   score_type a_score_in [SENSOR_COUNT];
   logic [LIMIT_W-1:0] a_steps_ff, a_steps_in;
   logic      a_below_ff, a_below_in;
   logic      a_load;

   logic signed [STEP_W:0] step_sum;
   logic [STEP_W:0] step_abs;
   score_type g [SENSOR_COUNT];
   score_type front_min, side_min;
   logic [SCORE_W:0] left_sum, right_sum;
   logic [SPEED_W-1:0] ring_sum;

   assign req_full = a_valid_ff & item_full;
   assign a_load = req_push & ~req_full;
   assign item_push = a_valid_ff & ~item_full;

   always_comb begin
      logic [PROX_W-1:0] clip;
      logic [2*PROX_W-1:0] prod;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         clip = (prox[i] > RAW_CLIP) ? RAW_CLIP : prox[i];
         prod = clip * RECIP_30;
         a_score_in[i] = SCORE_FULL - prod[22:16];
      end
      step_sum = (STEP_W+1)'(steps_left) + (STEP_W+1)'(steps_right);
      step_abs = step_sum[STEP_W] ? (STEP_W+1)'(-step_sum) : (STEP_W+1)'(step_sum);
      a_below_in = step_abs < (STEP_W+1)'(cfg.startup_step_limit);
      a_steps_in = step_abs[LIMIT_W-1:0];
      a_valid_in = a_load | (a_valid_ff & item_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (a_load) begin
         a_score_ff <= a_score_in;
         a_steps_ff <= a_steps_in;
         a_below_ff <= a_below_in;
      end
   end

   // gap fill runs once around the ring, each step seeing earlier writes
   always_comb begin
      g = a_score_ff;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (g[i] < SCORE_GAP && g[3'(i + 2)] < SCORE_GAP && g[3'(i + 3)] < SCORE_GAP) begin
            g[3'(i + 1)] = SCORE_GAP;
            if (g[3'(i + 3)] < g[3'(i + 2)]) begin
               g[3'(i + 2)] = SCORE_GAP;
            end
         end
      end
   end

   always_comb begin
      score_type m12, m56;
      m12 = (g[1] < g[2]) ? g[1] : g[2];
      m56 = (g[5] < g[6]) ? g[5] : g[6];
      side_min = (m12 < m56) ? m12 : m56;
      front_min = (g[0] < g[7]) ? g[0] : g[7];
      left_sum = (SCORE_W+1)'(g[6] >> 1) + (SCORE_W+1)'(g[5]);
      right_sum = (SCORE_W+1)'(g[1] >> 1) + (SCORE_W+1)'(g[2]);
      ring_sum = SPEED_W'(g[0]) + SPEED_W'(g[1]) + SPEED_W'(g[2])
               + SPEED_W'(g[5]) + SPEED_W'(g[6]) + SPEED_W'(g[7]);

      item.front_clear = front_min > cfg.clear_level;
      item.front_turn_right = g[0] > g[7];
      item.any_near = 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (g[i] < SCORE_FULL) begin
            item.any_near = 1'b1;
         end
      end
      item.side_hit = side_min <= cfg.clear_level;
      item.side_turn = (left_sum < right_sum) ? (SCORE_FULL - g[6]) : (SCORE_FULL - g[1]);
      item.surrounded = ring_sum < SPEED_W'(SCORE_FULL);
      item.steps_below = a_below_ff;
      item.steps = a_steps_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/ios_queue.sv =====
`default_nettype none

module ios_queue #(
   parameter int unsigned DEPTH = ios_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire ios_pkg::item_type wr_data,
   output logic                   full,
   input  wire logic              rd_en,
   output ios_pkg::item_type      rd_data,
   output logic                   empty
);
   import ios_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   item_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full = count_ff == CW'(DEPTH);
   assign empty = count_ff == '0;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset) !(wr_en && full))
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) !(rd_en && empty))
      else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/ios_back.sv =====
`default_nettype none

module ios_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ios_pkg::cfg_type                  cfg,
   input  wire ios_pkg::item_type                 item,
   input  wire logic                              item_empty,
   output logic                                   item_pop,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [ios_pkg::SPEED_W-1:0]            rsp_motor_speed,
   output logic signed [ios_pkg::TURN_W-1:0]      rsp_turn_rate,
   output logic                                   rsp_caution_lamp,
   output logic                                   rsp_front_clear_lamp
);
   import ios_pkg::*;

   logic out_valid_ff, out_valid_in;
   logic [SPEED_W-1:0] out_speed_ff, out_speed_in;
   logic signed [TURN_W-1:0] out_turn_ff, out_turn_in;
   logic out_caution_ff, out_caution_in;
   logic out_clear_ff, out_clear_in;
   logic [SPEED_W-1:0] prev_speed_ff, prev_speed_in;
   logic startup_done_ff, startup_done_in;

   assign item_pop = ~item_empty & (~out_valid_ff | rsp_pop);

   always_comb begin
      logic [SPEED_W-1:0] limit;
      out_caution_in = prev_speed_ff >= cfg.caution_speed;
      out_clear_in = item.front_clear;
      out_speed_in = cfg.cruise_speed;
      out_turn_in = '0;
      startup_done_in = startup_done_ff;
      if (out_caution_in && item.any_near && cfg.caution_speed < out_speed_in) begin
         out_speed_in = cfg.caution_speed;
      end
      if (!item.front_clear) begin
         out_speed_in = '0;
         out_turn_in = item.front_turn_right ? TURN_RIGHT_FULL : TURN_LEFT_FULL;
      end
      if (out_speed_in != '0 && item.side_hit) begin
         out_turn_in = TURN_W'(item.side_turn);
         out_speed_in = SIDE_SPEED;
      end
      if (item.surrounded) begin
         out_speed_in = '0;
         out_turn_in = TURN_RIGHT_FULL;
      end
      limit = SPEED_W'(item.steps) + STARTUP_SPEED_BASE;
      if (!startup_done_ff) begin
         if (item.steps_below) begin
            if (limit < out_speed_in) begin
               out_speed_in = limit;
            end
         end else begin
            startup_done_in = 1'b1;
         end
      end
      prev_speed_in = out_speed_in;
      out_valid_in = item_pop | (out_valid_ff & ~rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         prev_speed_ff <= '0;
         startup_done_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (item_pop) begin
            prev_speed_ff <= prev_speed_in;
            startup_done_ff <= startup_done_in;
         end
      end
      if (item_pop) begin
         out_speed_ff <= out_speed_in;
         out_turn_ff <= out_turn_in;
         out_caution_ff <= out_caution_in;
         out_clear_ff <= out_clear_in;
      end
   end

   assign rsp_empty = ~out_valid_ff;
   assign rsp_motor_speed = out_speed_ff;
   assign rsp_turn_rate = out_turn_ff;
   assign rsp_caution_lamp = out_caution_ff;
   assign rsp_front_clear_lamp = out_clear_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) startup_done_ff |=> startup_done_ff)
      else $error("startup flag cleared after being set");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_clear_ff) |-> out_speed_ff == '0)
      else $error("moving forward with front blocked");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_turn_ff <= TURN_LEFT_FULL && out_turn_ff >= TURN_RIGHT_FULL))
      else $error("turn out of range");
   assert property (@(posedge clock) disable iff (reset)
      item_pop |=> prev_speed_ff == out_speed_ff)
      else $error("previous speed not tracking last result");
`endif

endmodule

`default_nettype wire

// ===== rtl/ir_obstacle_steering.sv =====
// Obstacle steering controller, one control tick per transfer.
// Request channel: drive the eight proximity readings and two wheel step
// counts with req_push; a transfer happens on a clock edge with req_push high
// and req_full low. Response channel: while rsp_empty is low the oldest
// result sits on the rsp_ ports; it transfers on an edge with rsp_pop high.
// Path: the score register in the front end, one queue slot, then the output
// register in the back end. Throughput: one tick per cycle while rsp_pop keeps
// the output drained; the back end applies the speed rules, which depend on
// the previous tick's speed, combinationally as it pops each tick.
// Stalls: a short queue decouples the score/classify front end from the rule
// back end; if rsp_pop stays low the output register, the queue and then the
// front register fill, and req_full rises. Nothing is dropped.
// Configuration: csr_we writes csr_wdata to the register csr_index selects
// (0 cruise speed, 1 caution speed, 2 clear level, 3 startup step limit).
// Write only while no tick is in flight.
// Reset (synchronous, active high) empties the pipeline, restores register
// defaults, and clears previous speed and the startup-done flag.
`default_nettype none

module ir_obstacle_steering #(
   parameter int unsigned QUEUE_DEPTH = ios_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire logic [ios_pkg::PROX_W-1:0]            req_prox_front_right,
   input  wire logic [ios_pkg::PROX_W-1:0]            req_prox_right_front,
   input  wire logic [ios_pkg::PROX_W-1:0]            req_prox_right,
   input  wire logic [ios_pkg::PROX_W-1:0]            req_prox_back_right,
   input  wire logic [ios_pkg::PROX_W-1:0]            req_prox_back_left,
   input  wire logic [ios_pkg::PROX_W-1:0]            req_prox_left,
   input  wire logic [ios_pkg::PROX_W-1:0]            req_prox_left_front,
   input  wire logic [ios_pkg::PROX_W-1:0]            req_prox_front_left,
   input  wire logic signed [ios_pkg::STEP_W-1:0]     req_steps_left,
   input  wire logic signed [ios_pkg::STEP_W-1:0]     req_steps_right,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output logic [ios_pkg::SPEED_W-1:0]                rsp_motor_speed,
   output logic signed [ios_pkg::TURN_W-1:0]          rsp_turn_rate,
   output logic                                       rsp_caution_lamp,
   output logic                                       rsp_front_clear_lamp,
   input  wire logic                                  csr_we,
   input  wire logic [ios_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [ios_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import ios_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic [PROX_W-1:0] prox [SENSOR_COUNT];
   item_type front_item, queue_item;
   logic item_push, item_full, item_pop, item_empty;

   assign prox[0] = req_prox_front_right;
   assign prox[1] = req_prox_right_front;
   assign prox[2] = req_prox_right;
   assign prox[3] = req_prox_back_right;
   assign prox[4] = req_prox_back_left;
   assign prox[5] = req_prox_left;
   assign prox[6] = req_prox_left_front;
   assign prox[7] = req_prox_front_left;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CRUISE_SPEED: cfg_in.cruise_speed = csr_wdata;
            CSR_CAUTION_SPEED: cfg_in.caution_speed = csr_wdata;
            CSR_CLEAR_LEVEL: cfg_in.clear_level = csr_wdata[CLEAR_W-1:0];
            CSR_STARTUP_STEP_LIMIT: cfg_in.startup_step_limit = csr_wdata[LIMIT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cruise_speed <= CRUISE_SPEED_RESET;
         cfg_ff.caution_speed <= CAUTION_SPEED_RESET;
         cfg_ff.clear_level <= CLEAR_LEVEL_RESET;
         cfg_ff.startup_step_limit <= STARTUP_STEP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ios_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_push    (req_push),
      .req_full    (req_full),
      .prox        (prox),
      .steps_left  (req_steps_left),
      .steps_right (req_steps_right),
      .item_push   (item_push),
      .item_full   (item_full),
      .item        (front_item)
   );

   ios_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (item_push),
      .wr_data (front_item),
      .full    (item_full),
      .rd_en   (item_pop),
      .rd_data (queue_item),
      .empty   (item_empty)
   );

   ios_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .item                 (queue_item),
      .item_empty           (item_empty),
      .item_pop             (item_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_motor_speed      (rsp_motor_speed),
      .rsp_turn_rate        (rsp_turn_rate),
      .rsp_caution_lamp     (rsp_caution_lamp),
      .rsp_front_clear_lamp (rsp_front_clear_lamp)
   );

endmodule

`default_nettype wire
